// File: rtl/rlh_pkg.sv
`timescale 1ns / 1ps

package rlh_pkg;

   localparam int DEF_MAX_LEN    = 1023;
   localparam int DEF_COUNT_BITS = 32;
   localparam int BIN_BITS       = 10;
   localparam int SEQ_BITS       = 10;
   localparam int VALUE_BITS     = 32;
   localparam int REQ_DATA_BITS  = 16;

   typedef enum logic [1:0] {
      CMD_PUSH       = 2'd0,
      CMD_READ_BIN   = 2'd1,
      CMD_READ_TOTAL = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_SEQ   = 2'd0,
      KIND_BIN   = 2'd1,
      KIND_TOTAL = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_INC   = 2'd1,
      MEM_CLEAR = 2'd2
   } mem_op_type;

   // one transaction handed from the run tracker to the histogram stage
   typedef struct packed {
      logic                  valid;
      mem_op_type            op;
      logic                  has_rsp;
      kind_type              kind;
      logic [VALUE_BITS-1:0] value;
   } hist_op_type;

   function automatic logic [VALUE_BITS-1:0] report_sat(input logic [63:0] v);
      logic [VALUE_BITS-1:0] r;
      r = (|v[63:VALUE_BITS]) ? '1 : v[VALUE_BITS-1:0];
      return r;
   endfunction

endpackage

// File: rtl/run_length_histogram_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// req_     in   req_tvalid/req_tready  tuser: cmd; tlast: last; tdata: bit_req, bin
// rsp_     out  rsp_tvalid/rsp_tready  tuser: kind; tdata: value
//
// One transaction per cycle unless rsp stalls; results pass s1, then the output reg.
// Run state and the length-one bin live in registers; other bins in a 1R1W RAM,
// read at accept, updated in the update stage with forwarding of the previous write.
// After reset the RAM's MAX_LEN+1 entries are cleared, one a cycle; req_tready is low.
// A stalled result holds the output register; one more transaction waits in the update stage.

module run_length_histogram_unit #(
   parameter int MAX_LEN    = rlh_pkg::DEF_MAX_LEN,
   parameter int COUNT_BITS = rlh_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rlh_pkg::REQ_DATA_BITS-1:0]    req_tdata,   // [0] bit_req, [10:1] bin
   input  logic [1:0]                           req_tuser,   // [1:0] cmd
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rlh_pkg::VALUE_BITS-1:0]       rsp_tdata,   // [31:0] value
   output logic [1:0]                           rsp_tuser    // [1:0] kind
);
   import rlh_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_LEN + 1);

   logic                 accept;
   hist_op_type          op;
   logic [ADDR_BITS-1:0] op_addr;
   kind_type             rsp_kind;

   assign accept = req_tvalid && req_tready;

   rlh_run_tracker #(
      .MAX_LEN    (MAX_LEN),
      .COUNT_BITS (COUNT_BITS)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_tuser),
      .bit_req (req_tdata[0]),
      .last    (req_tlast),
      .bin     (req_tdata[BIN_BITS:1]),
      .op      (op),
      .op_addr (op_addr)
   );

   rlh_hist_update #(
      .MAX_LEN    (MAX_LEN),
      .COUNT_BITS (COUNT_BITS)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (op),
      .op_addr   (op_addr),
      .in_ready  (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_kind  (rsp_kind),
      .rsp_value (rsp_tdata),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tuser = rsp_kind;

endmodule

// File: rtl/rlh_ram.sv
`timescale 1ns / 1ps

module rlh_ram #(
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rlh_run_tracker.sv
`timescale 1ns / 1ps

module rlh_run_tracker #(
   parameter int MAX_LEN    = rlh_pkg::DEF_MAX_LEN,
   parameter int COUNT_BITS = rlh_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [1:0]                           cmd,
   input  logic                                 bit_req,
   input  logic                                 last,
   input  logic [rlh_pkg::BIN_BITS-1:0]         bin,
   output rlh_pkg::hist_op_type                 op,
   output logic [$clog2(MAX_LEN+1)-1:0]         op_addr
);
   import rlh_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_LEN + 1);
   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_LEN);
   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
   localparam logic [BIN_BITS-1:0] BIN_ONE = BIN_BITS'(1);

   logic                  run_bit_ff, run_bit_in;
   logic [LEN_BITS-1:0]   run_len_ff, run_len_in;
   logic                  in_seq_ff, in_seq_in;
   logic [SEQ_BITS-1:0]   seq_runs_ff, seq_runs_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] bin_one_ff, bin_one_in;

   logic                  change;
   logic                  open_seq;
   logic [LEN_BITS-1:0]   new_len;
   logic [1:0]            n_close;
   logic [1:0]            n_one;
   logic [SEQ_BITS-1:0]   seq_base;
   logic [SEQ_BITS:0]     seq_sum;
   logic [SEQ_BITS-1:0]   seq_next;
   logic [COUNT_BITS:0]   total_sum;
   logic [COUNT_BITS-1:0] total_next;
   logic [COUNT_BITS:0]   one_sum;
   logic [COUNT_BITS-1:0] one_next;
   logic                  bin_in_mem;

   always_comb begin
      open_seq = !in_seq_ff;
      change   = in_seq_ff && (bit_req != run_bit_ff);
      if (open_seq || change) begin
         new_len = LEN_ONE;
      end else if (run_len_ff < LEN_MAX) begin
         new_len = run_len_ff + LEN_ONE;
      end else begin
         new_len = run_len_ff;
      end
      n_close = 2'(change) + 2'(last);
      n_one   = 2'(change && (run_len_ff == LEN_ONE)) + 2'(last && (new_len == LEN_ONE));

      seq_base = open_seq ? '0 : seq_runs_ff;
      seq_sum  = {1'b0, seq_base} + (SEQ_BITS+1)'(n_close);
      seq_next = seq_sum[SEQ_BITS] ? '1 : seq_sum[SEQ_BITS-1:0];

      total_sum  = {1'b0, total_ff} + (COUNT_BITS+1)'(n_close);
      total_next = total_sum[COUNT_BITS] ? '1 : total_sum[COUNT_BITS-1:0];
      one_sum    = {1'b0, bin_one_ff} + (COUNT_BITS+1)'(n_one);
      one_next   = one_sum[COUNT_BITS] ? '1 : one_sum[COUNT_BITS-1:0];

      bin_in_mem = (bin > BIN_ONE) && (32'(bin) <= 32'(MAX_LEN));

      run_bit_in  = run_bit_ff;
      run_len_in  = run_len_ff;
      in_seq_in   = in_seq_ff;
      seq_runs_in = seq_runs_ff;
      total_in    = total_ff;
      bin_one_in  = bin_one_ff;

      op         = '0;
      op.op      = MEM_NONE;
      op.kind    = KIND_SEQ;
      op_addr    = '0;

      unique case (cmd)
         CMD_PUSH: begin
            if (open_seq || change) begin
               run_bit_in = bit_req;
            end
            total_in   = total_next;
            bin_one_in = one_next;
            if (change && (run_len_ff != LEN_ONE)) begin
               op.valid = 1'b1;
               op.op    = MEM_INC;
               op_addr  = run_len_ff;
            end else if (last && (new_len != LEN_ONE)) begin
               op.valid = 1'b1;
               op.op    = MEM_INC;
               op_addr  = new_len;
            end
            seq_runs_in = seq_next;
            if (last) begin
               in_seq_in  = 1'b0;
               run_len_in = '0;
               op.valid   = 1'b1;
               op.has_rsp = 1'b1;
               op.kind    = KIND_SEQ;
               op.value   = VALUE_BITS'(seq_next);
            end else begin
               in_seq_in  = 1'b1;
               run_len_in = new_len;
            end
         end
         CMD_READ_BIN: begin
            op.valid   = 1'b1;
            op.has_rsp = 1'b1;
            op.kind    = KIND_BIN;
            if (bin == BIN_ONE) begin
               op.value   = report_sat(64'(bin_one_ff));
               bin_one_in = '0;
            end else if (bin_in_mem) begin
               op.op   = MEM_CLEAR;
               op_addr = LEN_BITS'(bin);
            end
         end
         CMD_READ_TOTAL: begin
            op.valid   = 1'b1;
            op.has_rsp = 1'b1;
            op.kind    = KIND_TOTAL;
            op.value   = report_sat(64'(total_ff));
            total_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_bit_ff  <= 1'b0;
         run_len_ff  <= '0;
         in_seq_ff   <= 1'b0;
         seq_runs_ff <= '0;
         total_ff    <= '0;
         bin_one_ff  <= '0;
      end else if (accept) begin
         run_bit_ff  <= run_bit_in;
         run_len_ff  <= run_len_in;
         in_seq_ff   <= in_seq_in;
         seq_runs_ff <= seq_runs_in;
         total_ff    <= total_in;
         bin_one_ff  <= bin_one_in;
      end
   end

endmodule

// File: rtl/rlh_hist_update.sv
`timescale 1ns / 1ps

module rlh_hist_update #(
   parameter int MAX_LEN    = rlh_pkg::DEF_MAX_LEN,
   parameter int COUNT_BITS = rlh_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  rlh_pkg::hist_op_type                 op,
   input  logic [$clog2(MAX_LEN+1)-1:0]         op_addr,
   output logic                                 in_ready,
   output logic                                 rsp_valid,
   output rlh_pkg::kind_type                    rsp_kind,
   output logic [rlh_pkg::VALUE_BITS-1:0]       rsp_value,
   input  logic                                 rsp_ready
);
   import rlh_pkg::*;

   localparam int DEPTH     = MAX_LEN + 1;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   hist_op_type            s1_ff, s1_in;
   logic [ADDR_BITS-1:0]   s1_addr_ff;
   logic                   fwd_valid_ff;
   logic [ADDR_BITS-1:0]   fwd_addr_ff;
   logic [COUNT_BITS-1:0]  fwd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic                   init_done_ff;
   logic [ADDR_BITS-1:0]   clr_addr_ff;

   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0]  wr_data;
   logic                   rd_en;
   logic [COUNT_BITS-1:0]  rd_data;
   logic [COUNT_BITS-1:0]  cur_data;
   logic [COUNT_BITS-1:0]  upd_data;
   logic                   s1_mem;
   logic                   out_free;
   logic                   s1_go;
   logic [VALUE_BITS-1:0]  s1_value;

   rlh_ram #(
      .DEPTH     (DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (op_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      cur_data = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data;
      s1_mem   = s1_ff.valid && (s1_ff.op != MEM_NONE);
      upd_data = (s1_ff.op == MEM_INC) ?
                 ((&cur_data) ? cur_data : cur_data + COUNT_BITS'(1)) : '0;
      s1_value = (s1_ff.op == MEM_CLEAR) ? report_sat(64'(cur_data)) : s1_ff.value;
      out_free = !rsp_valid_ff || rsp_ready;
      s1_go    = s1_ff.valid && (!s1_ff.has_rsp || out_free);
      in_ready = init_done_ff && (!s1_ff.valid || s1_go);
      rd_en    = accept && (op.op != MEM_NONE);

      if (!init_done_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_go && s1_mem;
         wr_addr = s1_addr_ff;
         wr_data = upd_data;
      end

      if (accept) begin
         s1_in = op;
      end else if (s1_go) begin
         s1_in = '0;
      end else begin
         s1_in = s1_ff;
      end

      if (s1_go && s1_ff.has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         init_done_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
         if (!init_done_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               init_done_ff <= 1'b1;
            end
         end
         if (s1_go && s1_mem) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= op_addr;
      end
      if (s1_go && s1_mem) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= upd_data;
      end
      if (s1_go && s1_ff.has_rsp) begin
         rsp_kind_ff  <= s1_ff.kind;
         rsp_value_ff <= s1_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// File: rtl/rlh_checker.sv
`timescale 1ns / 1ps

module rlh_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rlh_pkg::VALUE_BITS-1:0]    rsp_tdata,
   input logic [1:0]                        rsp_tuser
);
   import rlh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("ready or result during clear pass");

   a_seq_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SEQ) |-> (rsp_tdata[VALUE_BITS-1:SEQ_BITS] == '0))
      else $error("sequence run count beyond its range");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a request two cycles before");

endmodule

bind run_length_histogram_unit rlh_checker u_rlh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
